/* rtl/core/imhpq_pkg.sv */
// Package for the indexed min-heap priority queue.
// Holds opcode and status codes, controller states, datapath commands and status.
// No dependencies.
package imhpq_pkg;

    localparam int ID_BITS     = 10;
    localparam int IN_KEY_BITS = 32;
    localparam int OCC_BITS    = 11;
    localparam int ST_BITS     = 2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_UPDATE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [ST_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_BITS-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_BITS-1:0] ST_BADID = 2'd3;

    typedef enum logic [4:0] {
        S_SWEEP, S_IDLE, S_CLEAR, S_LOOK, S_CHECK,
        S_POP1, S_POP2, S_POP3, S_POP4,
        S_UP0, S_UP1, S_UP2,
        S_DN0, S_DN1, S_DN2, S_DN3, S_DN4,
        S_FIN, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        CMD_IDLE, CMD_SWEEP, CMD_ACCEPT, CMD_CLEAR, CMD_LOOK,
        CMD_ERR_ID, CMD_ERR_FULL, CMD_ERR_EMPTY,
        CMD_INS_START, CMD_UPD_START,
        CMD_POP_TOP, CMD_POP_KEY, CMD_POP_LAST, CMD_POP_LKEY,
        CMD_UP_RD, CMD_UP_KEY, CMD_UP_SWAP,
        CMD_DN_RDL, CMD_DN_KL, CMD_DN_CL, CMD_DN_CR, CMD_DN_SWAP,
        CMD_FIN, CMD_EMIT
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic id_ok;
        logic present;
        logic full;
        logic cnt_zero;
        logic cnt_one;
        logic at_root;
        logic up_swap;
        logic has_l;
        logic has_r;
        logic best_moved;
        logic sweep_last;
        logic out_busy;
    } t_dp_status;

endpackage

/* rtl/core/imhpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/core/imhpq_ctrl.sv */
// Controller state machine for the indexed min-heap priority queue.
// Depends on imhpq_pkg; drives one command per cycle into imhpq_dpath.
module imhpq_ctrl import imhpq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_op        i_op,
    input  t_dp_status i_st,
    output t_cmd       o_cmd,
    output logic       o_in_stall
);

    t_state r_state, n_state;
    logic   r_swapped, n_swapped;
    logic   upd_first;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_swapped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_swapped <= n_swapped;
        end
    end

    // an update that has not moved up yet still has to try the way down
    assign upd_first  = (i_st.op == OP_UPDATE) && !r_swapped;
    assign o_in_stall = (r_state != S_IDLE);

    // next state and command
    always_comb begin
        n_state   = r_state;
        n_swapped = r_swapped;
        o_cmd     = CMD_IDLE;
        case (r_state)
            S_SWEEP: begin
                o_cmd = CMD_SWEEP;
                if (i_st.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = CMD_ACCEPT;
                    case (i_op)
                        OP_POP:   n_state = S_POP1;
                        OP_CLEAR: n_state = S_CLEAR;
                        default:  n_state = S_LOOK;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd   = CMD_CLEAR;
                n_state = S_DONE;
            end
            S_LOOK: begin
                o_cmd   = CMD_LOOK;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state   = S_DONE;
                n_swapped = 1'b0;
                if (i_st.op == OP_INSERT) begin
                    if (!i_st.id_ok || i_st.present) begin
                        o_cmd = CMD_ERR_ID;
                    end else if (i_st.full) begin
                        o_cmd = CMD_ERR_FULL;
                    end else begin
                        o_cmd   = CMD_INS_START;
                        n_state = S_UP0;
                    end
                end else begin
                    if (!i_st.present) begin
                        o_cmd = CMD_ERR_ID;
                    end else begin
                        o_cmd   = CMD_UPD_START;
                        n_state = S_UP0;
                    end
                end
            end
            S_POP1: begin
                if (i_st.cnt_zero) begin
                    o_cmd   = CMD_ERR_EMPTY;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = CMD_POP_TOP;
                    n_state = S_POP2;
                end
            end
            S_POP2: begin
                o_cmd   = CMD_POP_KEY;
                n_state = i_st.cnt_one ? S_DONE : S_POP3;
            end
            S_POP3: begin
                o_cmd   = CMD_POP_LAST;
                n_state = S_POP4;
            end
            S_POP4: begin
                o_cmd   = CMD_POP_LKEY;
                n_state = S_DN0;
            end
            S_UP0: begin
                if (i_st.at_root) begin
                    n_state = upd_first ? S_DN0 : S_FIN;
                end else begin
                    o_cmd   = CMD_UP_RD;
                    n_state = S_UP1;
                end
            end
            S_UP1: begin
                o_cmd   = CMD_UP_KEY;
                n_state = S_UP2;
            end
            S_UP2: begin
                if (i_st.up_swap) begin
                    o_cmd     = CMD_UP_SWAP;
                    n_swapped = 1'b1;
                    n_state   = S_UP0;
                end else begin
                    n_state = upd_first ? S_DN0 : S_FIN;
                end
            end
            S_DN0: begin
                if (i_st.has_l) begin
                    o_cmd   = CMD_DN_RDL;
                    n_state = S_DN1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DN1: begin
                o_cmd   = CMD_DN_KL;
                n_state = S_DN2;
            end
            S_DN2: begin
                o_cmd   = CMD_DN_CL;
                n_state = i_st.has_r ? S_DN3 : S_DN4;
            end
            S_DN3: begin
                o_cmd   = CMD_DN_CR;
                n_state = S_DN4;
            end
            S_DN4: begin
                if (i_st.best_moved) begin
                    o_cmd   = CMD_DN_SWAP;
                    n_state = S_DN0;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd   = CMD_FIN;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_st.out_busy) begin
                    o_cmd   = CMD_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/core/imhpq_dpath.sv */
// Datapath of the indexed min-heap: slot, key and position RAMs, hole registers,
// compares and the output register. Depends on imhpq_pkg and imhpq_ram.
module imhpq_dpath import imhpq_pkg::*; #(
    parameter int MAX_ITEMS = 1024,
    parameter int KEY_BITS  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic [1:0]                    i_opcode,
    input  logic [ID_BITS-1:0]            i_item_id,
    input  logic signed [IN_KEY_BITS-1:0] i_item_key,
    input  logic                          i_out_stall,
    output t_dp_status                    o_st,
    output logic                          o_out_valid,
    output logic [ID_BITS-1:0]            o_popped_id,
    output logic signed [IN_KEY_BITS-1:0] o_popped_key,
    output logic [ST_BITS-1:0]            o_status,
    output logic [OCC_BITS-1:0]           o_occupancy
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int XW = AW + 2;

    // RAM ports
    logic                heap_we, key_we, pos_we;
    logic [AW-1:0]       heap_waddr, heap_raddr, key_waddr, key_raddr, pos_waddr, pos_raddr;
    logic [ID_BITS-1:0]  heap_wdata, heap_rdata;
    logic [KEY_BITS-1:0] key_wdata, key_rdata;
    logic [AW-1:0]       pos_wdata, pos_rdata;

    // registers
    t_op                   r_op, n_op;
    logic [ID_BITS-1:0]    r_id, n_id, r_mv_id, n_mv_id, r_c_id, n_c_id, r_best_id, n_best_id;
    logic [KEY_BITS-1:0]   r_key, n_key, r_mv_key, n_mv_key, r_best_key, n_best_key;
    logic [AW-1:0]         r_p, n_p, r_i, n_i, r_best_slot, n_best_slot, r_sweep, n_sweep;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_sel, n_sel;
    logic [ST_BITS-1:0]    r_st, n_st;
    logic [ID_BITS-1:0]    r_pid, n_pid;
    logic [IN_KEY_BITS-1:0] r_pkey, n_pkey;
    logic                  r_o_valid, n_o_valid;
    logic [ID_BITS-1:0]    r_o_pid, n_o_pid;
    logic [IN_KEY_BITS-1:0] r_o_pkey, n_o_pkey;
    logic [ST_BITS-1:0]    r_o_st, n_o_st;
    logic [OCC_BITS-1:0]   r_o_occ, n_o_occ;

    // heap geometry around the hole
    logic [XW-1:0] slot_l, slot_r, cnt_x;
    logic [AW-1:0] parent;

    assign slot_l = {1'b0, r_i, 1'b1};
    assign slot_r = slot_l + XW'(1);
    assign cnt_x  = XW'(r_cnt);
    assign parent = AW'((r_i - AW'(1)) >> 1);

    imhpq_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_ITEMS)) u_heap_ram (
        .i_clk(i_clk), .i_we(heap_we), .i_waddr(heap_waddr), .i_wdata(heap_wdata),
        .i_raddr(heap_raddr), .o_rdata(heap_rdata)
    );

    imhpq_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_ITEMS)) u_key_ram (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_waddr), .i_wdata(key_wdata),
        .i_raddr(key_raddr), .o_rdata(key_rdata)
    );

    imhpq_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_pos_ram (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(pos_waddr), .i_wdata(pos_wdata),
        .i_raddr(pos_raddr), .o_rdata(pos_rdata)
    );

    // status toward the controller; an id is present when its slot holds it back
    always_comb begin
        o_st.op         = r_op;
        o_st.id_ok      = (32'(r_id) < 32'(MAX_ITEMS));
        o_st.present    = o_st.id_ok && (CW'(r_p) < r_cnt) && (heap_rdata == r_id);
        o_st.full       = (r_cnt == CW'(MAX_ITEMS));
        o_st.cnt_zero   = (r_cnt == '0);
        o_st.cnt_one    = (r_cnt == CW'(1));
        o_st.at_root    = (r_i == '0);
        o_st.up_swap    = ($signed(key_rdata) > $signed(r_mv_key));
        o_st.has_l      = (slot_l < cnt_x);
        o_st.has_r      = (slot_r < cnt_x);
        o_st.best_moved = r_sel;
        o_st.sweep_last = (r_sweep == AW'(MAX_ITEMS - 1));
        o_st.out_busy   = r_o_valid && i_out_stall;
    end

    // command decode: RAM ports and next register values
    always_comb begin
        heap_we = 1'b0; heap_waddr = r_i; heap_wdata = r_mv_id; heap_raddr = '0;
        key_we  = 1'b0; key_waddr = AW'(r_id); key_wdata = r_key; key_raddr = AW'(heap_rdata);
        pos_we  = 1'b0; pos_waddr = AW'(r_mv_id); pos_wdata = r_i; pos_raddr = AW'(i_item_id);

        n_op = r_op; n_id = r_id; n_key = r_key; n_p = r_p; n_cnt = r_cnt; n_i = r_i;
        n_mv_id = r_mv_id; n_mv_key = r_mv_key; n_c_id = r_c_id;
        n_best_id = r_best_id; n_best_key = r_best_key; n_best_slot = r_best_slot;
        n_sel = r_sel; n_sweep = r_sweep; n_st = r_st; n_pid = r_pid; n_pkey = r_pkey;
        n_o_pid = r_o_pid; n_o_pkey = r_o_pkey; n_o_st = r_o_st; n_o_occ = r_o_occ;
        n_o_valid = (r_o_valid && !i_out_stall) ? 1'b0 : r_o_valid;

        case (i_cmd)
            CMD_SWEEP: begin
                pos_we    = 1'b1;
                pos_waddr = r_sweep;
                pos_wdata = '0;
                n_sweep   = r_sweep + AW'(1);
            end
            CMD_ACCEPT: begin
                n_op       = t_op'(i_opcode);
                n_id       = i_item_id;
                n_key      = KEY_BITS'(i_item_key);
                pos_raddr  = AW'(i_item_id);
                heap_raddr = '0;
                n_st       = ST_OK;
                n_pid      = '0;
                n_pkey     = '0;
            end
            CMD_CLEAR: n_cnt = '0;
            CMD_LOOK: begin
                n_p        = pos_rdata;
                heap_raddr = pos_rdata;
            end
            CMD_ERR_ID:    n_st = ST_BADID;
            CMD_ERR_FULL:  n_st = ST_FULL;
            CMD_ERR_EMPTY: n_st = ST_EMPTY;
            CMD_INS_START: begin
                key_we   = 1'b1;
                n_mv_id  = r_id;
                n_mv_key = r_key;
                n_i      = AW'(r_cnt);
                n_cnt    = r_cnt + CW'(1);
            end
            CMD_UPD_START: begin
                key_we   = 1'b1;
                n_mv_id  = r_id;
                n_mv_key = r_key;
                n_i      = r_p;
            end
            CMD_POP_TOP: begin
                n_pid     = heap_rdata;
                key_raddr = AW'(heap_rdata);
            end
            CMD_POP_KEY: begin
                n_pkey     = IN_KEY_BITS'($signed(key_rdata));
                n_cnt      = r_cnt - CW'(1);
                heap_raddr = AW'(r_cnt - CW'(1));
            end
            CMD_POP_LAST: begin
                n_mv_id   = heap_rdata;
                key_raddr = AW'(heap_rdata);
            end
            CMD_POP_LKEY: begin
                n_mv_key = key_rdata;
                n_i      = '0;
            end
            CMD_UP_RD: heap_raddr = parent;
            CMD_UP_KEY: begin
                n_best_id = heap_rdata;
                key_raddr = AW'(heap_rdata);
            end
            CMD_UP_SWAP: begin
                // pull the parent down into the hole
                heap_we    = 1'b1;
                heap_wdata = r_best_id;
                pos_we     = 1'b1;
                pos_waddr  = AW'(r_best_id);
                n_i        = parent;
            end
            CMD_DN_RDL: heap_raddr = AW'(slot_l);
            CMD_DN_KL: begin
                n_c_id     = heap_rdata;
                key_raddr  = AW'(heap_rdata);
                heap_raddr = AW'(slot_r);
            end
            CMD_DN_CL: begin
                // left child wins only on a strictly smaller key
                if ($signed(r_mv_key) > $signed(key_rdata)) begin
                    n_best_id   = r_c_id;
                    n_best_key  = key_rdata;
                    n_best_slot = AW'(slot_l);
                    n_sel       = 1'b1;
                end else begin
                    n_best_id   = r_mv_id;
                    n_best_key  = r_mv_key;
                    n_best_slot = r_i;
                    n_sel       = 1'b0;
                end
                n_c_id    = heap_rdata;
                key_raddr = AW'(heap_rdata);
            end
            CMD_DN_CR: begin
                if ($signed(r_best_key) > $signed(key_rdata)) begin
                    n_best_id   = r_c_id;
                    n_best_key  = key_rdata;
                    n_best_slot = AW'(slot_r);
                    n_sel       = 1'b1;
                end
            end
            CMD_DN_SWAP: begin
                // lift the smaller child up into the hole
                heap_we    = 1'b1;
                heap_wdata = r_best_id;
                pos_we     = 1'b1;
                pos_waddr  = AW'(r_best_id);
                n_i        = r_best_slot;
            end
            CMD_FIN: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            CMD_EMIT: begin
                n_o_valid = 1'b1;
                n_o_pid   = r_pid;
                n_o_pkey  = r_pkey;
                n_o_st    = r_st;
                n_o_occ   = OCC_BITS'(r_cnt);
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_sweep   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_sweep   <= n_sweep;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_id <= n_id; r_key <= n_key; r_p <= n_p; r_i <= n_i;
        r_mv_id <= n_mv_id; r_mv_key <= n_mv_key; r_c_id <= n_c_id;
        r_best_id <= n_best_id; r_best_key <= n_best_key; r_best_slot <= n_best_slot;
        r_sel <= n_sel; r_st <= n_st; r_pid <= n_pid; r_pkey <= n_pkey;
        r_o_pid <= n_o_pid; r_o_pkey <= n_o_pkey; r_o_st <= n_o_st; r_o_occ <= n_o_occ;
    end

    assign o_out_valid  = r_o_valid;
    assign o_popped_id  = r_o_pid;
    assign o_popped_key = $signed(r_o_pkey);
    assign o_status     = r_o_st;
    assign o_occupancy  = r_o_occ;

endmodule

/* rtl/core/indexed_min_heap_priority_queue.sv */
// Indexed binary min-heap priority queue, one item at a time: a new item is taken only
// once the last one is through. Clear, empty pop and bad id move nothing; insert moves up
// level by level, pop moves the last item down from the root level by level; update mixes both.
// The result is valid in the same cycle that the next item can be taken.
// Reset: synchronous, active low; empties the heap, then sweeps every entry of the
// position RAM to zero before the first item is taken.
module indexed_min_heap_priority_queue import imhpq_pkg::*; #(
    parameter int MAX_ITEMS = 1024,
    parameter int KEY_BITS  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [ID_BITS-1:0]            i_item_id,
    input  logic signed [IN_KEY_BITS-1:0] i_item_key,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ID_BITS-1:0]            o_popped_id,
    output logic signed [IN_KEY_BITS-1:0] o_popped_key,
    output logic [ST_BITS-1:0]            o_status,
    output logic [OCC_BITS-1:0]           o_occupancy
);

    t_cmd       cmd;
    t_dp_status dp_st;

    imhpq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_op(t_op'(i_opcode)), .i_st(dp_st), .o_cmd(cmd), .o_in_stall(o_in_stall)
    );

    imhpq_dpath #(.MAX_ITEMS(MAX_ITEMS), .KEY_BITS(KEY_BITS)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_opcode(i_opcode),
        .i_item_id(i_item_id), .i_item_key(i_item_key), .i_out_stall(i_out_stall),
        .o_st(dp_st), .o_out_valid(o_out_valid), .o_popped_id(o_popped_id),
        .o_popped_key(o_popped_key), .o_status(o_status), .o_occupancy(o_occupancy)
    );

endmodule
